>>> rtl/jsu_pkg.sv
package jsu_pkg;

   // Decoder phase within one quoted string
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_ESC,
      PH_HEX
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_DONE   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Configuration defaults and hard limits
   localparam int BUFFER_SIZE_RESET = 256;
   localparam int MAX_BUFFER        = 4096;
   localparam int LENGTH_CAP        = 4096;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int LEN_W  = 12;
   localparam int CFG_W  = 13;
   localparam int ACC_W  = 16;

   // Decoder state carried between transactions
   typedef struct packed {
      phase_type         phase;
      logic [1:0]        hex_count;
      logic [ACC_W-1:0]  code_acc;
      logic [LEN_W-1:0]  stored_count;
   } state_type;

   // One result slot
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  out_length;
   } result_type;

endpackage

>>> rtl/jsu_decode.sv
module jsu_decode (
   input  jsu_pkg::state_type               state,
   input  logic [jsu_pkg::BYTE_W-1:0]       in_byte,
   input  logic                             first_byte,
   input  logic [jsu_pkg::LEN_W-1:0]        keep_limit,
   output jsu_pkg::state_type               state_next,
   output jsu_pkg::result_type              result
);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [jsu_pkg::ACC_W-1:0] ASCII_END = 16'h0080;

   // Map one character to its hex digit value, non-hex gives zero
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'h30;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'h57;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'h37;
      end
      return d[3:0];
   endfunction

   logic                         emit_req;
   logic [7:0]                   emit_byte;
   logic                         finish;
   logic [jsu_pkg::ACC_W-1:0]    acc_shift;

   assign acc_shift = {state.code_acc[jsu_pkg::ACC_W-5:0], hex_value(in_byte)};

   always_comb begin
      state_next = state;
      result     = '0;
      emit_req   = 1'b0;
      emit_byte  = in_byte;
      finish     = 1'b0;

      if (first_byte) begin
         // Start over on the marked byte, reject without an opening quote
         state_next.hex_count    = '0;
         state_next.code_acc     = '0;
         state_next.stored_count = '0;
         if (in_byte != CH_QUOTE) begin
            state_next.phase = jsu_pkg::PH_IDLE;
            result.valid     = 1'b1;
            result.kind      = jsu_pkg::KIND_REJECT;
         end else begin
            state_next.phase = jsu_pkg::PH_BODY;
         end
      end else begin
         case (state.phase)
            jsu_pkg::PH_BODY: begin
               if (in_byte == CH_NUL || in_byte == CH_QUOTE) begin
                  finish = 1'b1;
               end else if (in_byte == CH_BSL) begin
                  state_next.phase = jsu_pkg::PH_ESC;
               end else begin
                  emit_req = 1'b1;
               end
            end
            jsu_pkg::PH_ESC: begin
               if (in_byte == CH_NUL) begin
                  finish = 1'b1;
               end else if (in_byte == CH_U) begin
                  state_next.phase     = jsu_pkg::PH_HEX;
                  state_next.hex_count = '0;
                  state_next.code_acc  = '0;
               end else begin
                  state_next.phase = jsu_pkg::PH_BODY;
                  emit_req         = 1'b1;
                  case (in_byte)
                     CH_N:    emit_byte = CH_LF;
                     CH_R:    emit_byte = CH_CR;
                     CH_T:    emit_byte = CH_TAB;
                     default: emit_byte = in_byte;
                  endcase
               end
            end
            jsu_pkg::PH_HEX: begin
               if (in_byte == CH_NUL) begin
                  finish = 1'b1;
               end else if (state.hex_count != 2'd3) begin
                  state_next.hex_count = state.hex_count + 2'd1;
                  state_next.code_acc  = acc_shift;
               end else begin
                  state_next.phase     = jsu_pkg::PH_BODY;
                  state_next.hex_count = '0;
                  state_next.code_acc  = '0;
                  emit_req             = 1'b1;
                  emit_byte            = (acc_shift < ASCII_END) ? acc_shift[7:0] : CH_QMARK;
               end
            end
            default: begin
               state_next.phase = jsu_pkg::PH_IDLE;
            end
         endcase

         // Close the string and report the stored length
         if (finish) begin
            state_next.phase     = jsu_pkg::PH_IDLE;
            state_next.hex_count = '0;
            state_next.code_acc  = '0;
            result.valid         = 1'b1;
            result.kind          = jsu_pkg::KIND_DONE;
            result.out_length    = state.stored_count;
         end

         // Store a decoded byte while room is left, drop it otherwise
         if (emit_req && (state.stored_count < keep_limit)) begin
            state_next.stored_count = state.stored_count + 1'b1;
            result.valid            = 1'b1;
            result.kind             = jsu_pkg::KIND_BYTE;
            result.out_byte         = emit_byte;
         end
      end
   end

endmodule

>>> rtl/json_string_unescaper.sv
// JSON string unescaper.
// Feed the raw bytes of one quoted string on the req_ channel, opening quote
// first with req_first_byte set. Each decoded byte comes out on the rsp_
// channel with kind 0; the closing quote or a NUL gives one kind 1
// transaction carrying the stored length; a marked first byte that is not a
// quote gives one kind 2 transaction. Bytes past buffer_size minus one, and
// bytes that only advance an escape, give no transaction.
// An accepted byte is held in the input register and its result is loaded
// into the rsp_ register when it advances. Throughput is one byte per cycle
// while the result slot is free or being taken, set by the single decode
// step between the input register and the result register.
// csr_wr_en/csr_wr_data write buffer_size; write only while idle.
// Reset empties both registers, returns to the idle phase and sets
// buffer_size to 256. When rsp_ready is low the result holds, the byte in the
// input register waits, and req_ready drops once that register is occupied.
module json_string_unescaper #(
   parameter int MaxBuffer = jsu_pkg::MAX_BUFFER
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jsu_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          req_first_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [jsu_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [jsu_pkg::KIND_W-1:0]    rsp_kind,
   output logic [jsu_pkg::LEN_W-1:0]     rsp_out_length,
   input  logic                          csr_wr_en,
   input  logic [jsu_pkg::CFG_W-1:0]     csr_wr_data
);

   localparam int CapMax = (MaxBuffer < jsu_pkg::LENGTH_CAP) ? MaxBuffer : jsu_pkg::LENGTH_CAP;
   localparam int CapReset =
      (jsu_pkg::BUFFER_SIZE_RESET < CapMax) ? jsu_pkg::BUFFER_SIZE_RESET : CapMax;
   localparam logic [jsu_pkg::CFG_W-1:0] CAP_MAX     = jsu_pkg::CFG_W'(CapMax);
   localparam logic [jsu_pkg::LEN_W-1:0] LIMIT_RESET = jsu_pkg::LEN_W'(CapReset - 1);

   logic                          in_valid_ff, in_valid_in;
   logic [jsu_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                          in_first_ff;
   jsu_pkg::state_type            state_ff, state_in;
   jsu_pkg::result_type           out_ff, result;
   logic [jsu_pkg::LEN_W-1:0]     keep_limit_ff, keep_limit_in;
   logic [jsu_pkg::CFG_W-1:0]     cap;
   logic                          advance;
   logic                          req_fire;

   // Move the held byte on when the result slot is free or being taken
   assign advance   = in_valid_ff && (!out_ff.valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   // Keep limit: min(buffer_size, capacity) minus one, zero stays zero
   assign cap           = (csr_wr_data > CAP_MAX) ? CAP_MAX : csr_wr_data;
   assign keep_limit_in = (cap == '0) ? '0 : jsu_pkg::LEN_W'(cap - 1'b1);

   jsu_decode u_decode (
      .state      (state_ff),
      .in_byte    (in_byte_ff),
      .first_byte (in_first_ff),
      .keep_limit (keep_limit_ff),
      .state_next (state_in),
      .result     (result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_fire) begin
         in_byte_ff  <= req_in_byte;
         in_first_ff <= req_first_byte;
      end
   end

   // Decoder state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= jsu_pkg::PH_IDLE;
         state_ff.hex_count    <= '0;
         state_ff.code_acc     <= '0;
         state_ff.stored_count <= '0;
         keep_limit_ff         <= LIMIT_RESET;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            keep_limit_ff <= keep_limit_in;
         end
      end
   end

   // Result register: load on advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff.valid <= result.valid;
      end else if (rsp_ready) begin
         out_ff.valid <= 1'b0;
      end
      if (advance) begin
         out_ff.out_byte   <= result.out_byte;
         out_ff.kind       <= result.kind;
         out_ff.out_length <= result.out_length;
      end
   end

   assign rsp_valid      = out_ff.valid;
   assign rsp_out_byte   = out_ff.out_byte;
   assign rsp_kind       = out_ff.kind;
   assign rsp_out_length = out_ff.out_length;

`ifndef ASSERT_OFF
   a_hex_only_in_hex: assert property (@(posedge clock) disable iff (reset)
      state_ff.hex_count != '0 |-> state_ff.phase == jsu_pkg::PH_HEX)
      else $error("hex count set outside a unicode escape");

   a_acc_only_in_hex: assert property (@(posedge clock) disable iff (reset)
      state_ff.code_acc != '0 |-> state_ff.phase == jsu_pkg::PH_HEX)
      else $error("code accumulator set outside a unicode escape");

   a_length_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != jsu_pkg::KIND_DONE |-> rsp_out_length == '0)
      else $error("length carried on a non-finish transaction");

   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != jsu_pkg::KIND_BYTE |-> rsp_out_byte == '0)
      else $error("byte carried on a non-data transaction");

   a_no_advance_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> $stable(state_ff))
      else $error("decoder state moved without a held byte");
`endif

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT       = 2000;
   localparam int SETTLE_CYCLES     = 8;
   localparam int SEGMENTS          = 9;
   localparam int ITEMS_PER_SEGMENT = 139;
   localparam int REPORT_LIMIT      = 10;

   // Character codes the decoder reacts to
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_QMARK     = 8'h3F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   typedef struct packed {
      logic [jsu_pkg::BYTE_W-1:0] out_byte;
      logic [jsu_pkg::KIND_W-1:0] kind;
      logic [jsu_pkg::LEN_W-1:0]  out_length;
   } decoded_type;

   // Track decoder state and hold the decoded transactions still owed
   class unescape_scoreboard;
      logic [jsu_pkg::CFG_W-1:0] buffer_size;
      jsu_pkg::phase_type        phase;
      logic [1:0]                hex_count;
      logic [jsu_pkg::ACC_W-1:0] code_acc;
      logic [jsu_pkg::LEN_W-1:0] stored_count;
      decoded_type               owed_q[$];
      int                        mismatches;

      function new();
         buffer_size  = jsu_pkg::CFG_W'(jsu_pkg::BUFFER_SIZE_RESET);
         phase        = jsu_pkg::PH_IDLE;
         hex_count    = '0;
         code_acc     = '0;
         stored_count = '0;
         mismatches   = 0;
      endfunction

      function void set_buffer_size(logic [jsu_pkg::CFG_W-1:0] value);
         buffer_size = value;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function int keep_limit();
         int cap;
         cap = int'(buffer_size);
         if (cap > jsu_pkg::MAX_BUFFER) cap = jsu_pkg::MAX_BUFFER;
         if (cap > jsu_pkg::LENGTH_CAP) cap = jsu_pkg::LENGTH_CAP;
         return (cap == 0) ? 0 : cap - 1;
      endfunction

      function logic [3:0] hex_value(logic [7:0] b);
         logic [7:0] d;
         d = 8'h00;
         if (b >= "0" && b <= "9") d = b - 8'h30;
         else if (b >= "a" && b <= "f") d = b - 8'h57;
         else if (b >= "A" && b <= "F") d = b - 8'h37;
         return d[3:0];
      endfunction

      function void owe(logic [7:0] b, logic [1:0] k, logic [jsu_pkg::LEN_W-1:0] len);
         decoded_type item;
         item.out_byte   = b;
         item.kind       = k;
         item.out_length = len;
         owed_q.push_back(item);
      endfunction

      // Keep the byte only while the destination has room
      function void store_byte(logic [7:0] b);
         if (stored_count < keep_limit()) begin
            stored_count++;
            owe(b, jsu_pkg::KIND_BYTE, '0);
         end
      endfunction

      function void finish_string();
         phase     = jsu_pkg::PH_IDLE;
         hex_count = '0;
         code_acc  = '0;
         owe('0, jsu_pkg::KIND_DONE, stored_count);
      endfunction

      // Advance the decoder by one accepted byte; return 1 if it was ignored
      function bit note_request(logic [7:0] b, logic first);
         logic [7:0]                decoded;
         logic [jsu_pkg::ACC_W-1:0] next_acc;
         if (first) begin
            hex_count    = '0;
            code_acc     = '0;
            stored_count = '0;
            if (b != CH_QUOTE) begin
               phase = jsu_pkg::PH_IDLE;
               owe('0, jsu_pkg::KIND_REJECT, '0);
            end else begin
               phase = jsu_pkg::PH_BODY;
            end
            return 0;
         end
         case (phase)
            jsu_pkg::PH_BODY: begin
               if (b == CH_NUL || b == CH_QUOTE) finish_string();
               else if (b == CH_BACKSLASH) phase = jsu_pkg::PH_ESC;
               else store_byte(b);
            end
            jsu_pkg::PH_ESC: begin
               if (b == CH_NUL) begin
                  finish_string();
               end else if (b == CH_U) begin
                  phase     = jsu_pkg::PH_HEX;
                  hex_count = '0;
                  code_acc  = '0;
               end else begin
                  phase = jsu_pkg::PH_BODY;
                  if (b == CH_N) decoded = CH_LF;
                  else if (b == CH_R) decoded = CH_CR;
                  else if (b == CH_T) decoded = CH_TAB;
                  else decoded = b;
                  store_byte(decoded);
               end
            end
            jsu_pkg::PH_HEX: begin
               if (b == CH_NUL) begin
                  finish_string();
               end else begin
                  next_acc = {code_acc[jsu_pkg::ACC_W-5:0], hex_value(b)};
                  if (hex_count < 2'd3) begin
                     code_acc = next_acc;
                     hex_count++;
                  end else begin
                     decoded   = (next_acc < 16'h0080) ? next_acc[7:0] : CH_QMARK;
                     phase     = jsu_pkg::PH_BODY;
                     hex_count = '0;
                     code_acc  = '0;
                     store_byte(decoded);
                  end
               end
            end
            default: begin
               phase = jsu_pkg::PH_IDLE;
               return 1;
            end
         endcase
         return 0;
      endfunction

      // Compare one response transaction with the oldest one owed
      function void check_response(logic [7:0] b, logic [1:0] k,
                                   logic [jsu_pkg::LEN_W-1:0] len);
         decoded_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: byte %02h kind %0d length %0d", b, k, len);
            return;
         end
         want = owed_q.pop_front();
         if (want.out_byte !== b || want.kind !== k || want.out_length !== len) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response mismatch: expected byte %02h kind %0d length %0d,",
                        want.out_byte, want.kind, want.out_length,
                        " got byte %02h kind %0d length %0d", b, k, len);
         end
      endfunction
   endclass

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [jsu_pkg::BYTE_W-1:0] req_in_byte    = '0;
   logic                       req_first_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [jsu_pkg::BYTE_W-1:0] rsp_out_byte;
   logic [jsu_pkg::KIND_W-1:0] rsp_kind;
   logic [jsu_pkg::LEN_W-1:0]  rsp_out_length;
   logic                       csr_wr_en      = 1'b0;
   logic [jsu_pkg::CFG_W-1:0]  csr_wr_data    = '0;

   unescape_scoreboard sb = new();

   int send_idle_pct = 13;
   int recv_idle_pct = 60;
   int items_counted = 0;
   int quiet_cycles  = 0;
   int segment_target;
   int buffer_sizes [SEGMENTS] = '{1, 4096, 2, 7, 256, 4096, 1, 33, 3};

   json_string_unescaper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_first_byte (req_first_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_out_length (rsp_out_length),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         sb.check_response(rsp_out_byte, rsp_kind, rsp_out_length);
      if (req_valid && req_ready) begin
         if (!sb.note_request(req_in_byte, req_first_byte)) items_counted++;
      end
      if (csr_wr_en) sb.set_buffer_size(csr_wr_data);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
   end

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
   end

   // End the run when nothing moves for too long
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("json_string_unescaper regression: fail");
      $finish;
   end

   // Present one byte, with random idle cycles ahead of it, and hold until accepted
   task automatic send_item(logic [7:0] b, logic first);
      while (int'($urandom_range(99)) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_first_byte <= first;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // Drop valid, wait for every owed transaction, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_buffer_size(logic [jsu_pkg::CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(1) == 1 ? "a" : "A") + v - 10);
   endfunction

   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
      return b;
   endfunction

   function automatic logic [7:0] pick_escape();
      logic [7:0] b;
      case ($urandom_range(9))
         0: b = CH_N;
         1: b = CH_R;
         2: b = CH_T;
         3: b = CH_QUOTE;
         4: b = CH_BACKSLASH;
         5: b = CH_SLASH;
         default: begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_U);
         end
      endcase
      return b;
   endfunction

   // Send a unicode escape with the given number of digit characters
   task automatic send_unicode(int digits);
      logic [7:0] c;
      bit         low_code;
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_U, 1'b0);
      low_code = ($urandom_range(1) == 1);
      for (int k = 0; k < digits; k++) begin
         if ($urandom_range(99) < 12) c = 8'($urandom_range(1, 255));
         else if (low_code && k < 2) c = "0";
         else if (low_code && k == 2) c = hex_char(int'($urandom_range(7)));
         else c = hex_char(int'($urandom_range(15)));
         send_item(c, 1'b0);
      end
   endtask

   // Mostly well-formed strings with random content, some noise and broken ones
   task automatic send_random_string();
      int shape;
      int tokens;
      int pick;
      int ending;
      shape = int'($urandom_range(99));
      if (shape < 6) begin
         repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'b0);
         return;
      end
      if (shape < 12) begin
         send_item(8'($urandom_range(255)), 1'b1);
         return;
      end
      send_item(CH_QUOTE, 1'b1);
      tokens = ($urandom_range(9) == 0) ? int'($urandom_range(20, 60))
                                        : int'($urandom_range(0, 12));
      repeat (tokens) begin
         pick = int'($urandom_range(99));
         if (pick < 50) begin
            send_item(pick_plain(), 1'b0);
         end else if (pick < 75) begin
            send_item(CH_BACKSLASH, 1'b0);
            send_item(pick_escape(), 1'b0);
         end else if (pick < 90) begin
            send_unicode(4);
         end else begin
            send_item(8'($urandom_range(1, 255)), 1'b0);
         end
      end
      // Close with a quote or a NUL, cut an escape short, or leave open for a restart
      ending = int'($urandom_range(99));
      if (ending < 75) begin
         send_item(CH_QUOTE, 1'b0);
      end else if (ending < 83) begin
         send_item(CH_NUL, 1'b0);
      end else if (ending < 90) begin
         if ($urandom_range(2) == 0) send_item(CH_BACKSLASH, 1'b0);
         else send_unicode(int'($urandom_range(0, 3)));
         send_item(CH_NUL, 1'b0);
      end
   endtask

   task automatic send_directed();
      // Stray byte while idle, then a rejected opening byte
      send_item("x", 1'b0);
      send_item(CH_NUL, 1'b1);
      // Escapes, highest low code, top byte, quote as a non-hex digit
      send_item(CH_QUOTE, 1'b1);
      send_text("\\n\\u007F");
      send_item(8'hFF, 1'b0);
      send_text("\\uFf8\"");
      send_item(CH_QUOTE, 1'b0);
      // Restart mid-string, then NUL right after a backslash
      send_item(CH_QUOTE, 1'b1);
      send_item("A", 1'b0);
      send_item(CH_QUOTE, 1'b1);
      send_item(CH_BACKSLASH, 1'b0);
      send_item(CH_NUL, 1'b0);
      // NUL inside a unicode escape
      send_item(CH_QUOTE, 1'b1);
      send_text("\\u1");
      send_item(CH_NUL, 1'b0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_directed();
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         write_buffer_size(jsu_pkg::CFG_W'(buffer_sizes[seg]));
         if (seg == 3) begin
            send_idle_pct = 60;
            recv_idle_pct = 13;
         end else if (seg == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         segment_target = items_counted + ITEMS_PER_SEGMENT;
         while (items_counted < segment_target) send_random_string();
      end
      settle();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("json_string_unescaper regression: pass");
      end else begin
         $display("json_string_unescaper regression: fail");
      end
      $finish;
   end

endmodule
